// ===== hw/rtl/sce_pkg.sv =====
`timescale 1ns / 1ps
package sce_pkg;

  // field widths of the stream payloads
  localparam int SIG_W       = 16;
  localparam int CHAN_W      = 12;
  localparam int ETA_W       = 17;
  localparam int STAT_W      = 2;
  localparam int IN_TDATA_W  = 32;
  localparam int OUT_TDATA_W = 24;

  // defaults for the top level parameters
  localparam int MAX_STRIPS_DEF    = 64;
  localparam int ETA_FRAC_BITS_DEF = 16;

  // result status codes
  localparam logic [STAT_W-1:0] STAT_OK     = 2'd0;
  localparam logic [STAT_W-1:0] STAT_SINGLE = 2'd1;
  localparam logic [STAT_W-1:0] STAT_NONPOS = 2'd2;

  // controller to datapath
  typedef struct packed {
    logic take;      // strip transfer, update cluster tracking
    logic eval;      // pick second strip, set up divide, clear cluster
    logic step;      // one restoring divide step
    logic load_out;  // move finished result into output register
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic need_div;  // valid during eval
    logic div_last;  // final divide step
  } dp_sts_t;

endpackage

// ===== hw/rtl/sce_ctrl.sv =====
`timescale 1ns / 1ps
module sce_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  input  logic              in_tlast,
  output logic              in_tready,
  output logic              out_tvalid,
  input  logic              out_tready,
  output sce_pkg::dp_cmd_t  cmd,
  input  sce_pkg::dp_sts_t  sts
);
  import sce_pkg::*;

  typedef enum logic [3:0] {
    S_COLLECT = 4'b0001,
    S_EVAL    = 4'b0010,
    S_DIV     = 4'b0100,
    S_WAIT    = 4'b1000
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  always_comb begin
    state_nxt     = state_r;
    cmd           = '0;
    in_tready     = 1'b0;
    out_valid_nxt = out_valid_r && !out_tready;
    case (state_r)
      S_COLLECT: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.take = 1'b1;
          if (in_tlast) state_nxt = S_EVAL;
        end
      end
      S_EVAL: begin
        cmd.eval  = 1'b1;
        state_nxt = sts.need_div ? S_DIV : S_WAIT;
      end
      S_DIV: begin
        cmd.step = 1'b1;
        if (sts.div_last) state_nxt = S_WAIT;
      end
      S_WAIT: begin
        if (!out_valid_r || out_tready) begin
          cmd.load_out  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_COLLECT;
        end
      end
      default: state_nxt = S_COLLECT;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_COLLECT;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_tvalid = out_valid_r;

endmodule

// ===== hw/rtl/sce_dp.sv =====
`timescale 1ns / 1ps
module sce_dp #(
  parameter int MAX_STRIPS    = sce_pkg::MAX_STRIPS_DEF,
  parameter int ETA_FRAC_BITS = sce_pkg::ETA_FRAC_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  sce_pkg::dp_cmd_t            cmd,
  output sce_pkg::dp_sts_t            sts,
  input  logic [sce_pkg::SIG_W-1:0]   in_sig,
  input  logic [sce_pkg::CHAN_W-1:0]  in_chan,
  output logic [sce_pkg::ETA_W-1:0]   eta,
  output logic [sce_pkg::STAT_W-1:0]  status
);
  import sce_pkg::*;

  localparam int CNT_W = $clog2(MAX_STRIPS + 1);
  localparam int QW    = ETA_FRAC_BITS + 1;
  localparam int DC_W  = $clog2(ETA_FRAC_BITS);

  // cluster tracking
  logic [CNT_W-1:0]         cnt_r;
  logic signed [SIG_W-1:0]  peak_sig_r, left_sig_r, right_sig_r, prev_sig_r;
  logic [CHAN_W-1:0]        peak_ch_r, left_ch_r, right_ch_r, prev_ch_r;
  logic                     at_first_r, rpend_r, rpres_r;

  // divide and result
  logic [SIG_W-1:0]   rem_r, den_r;
  logic [QW-1:0]      res_r;
  logic [STAT_W-1:0]  rstat_r;
  logic [DC_W-1:0]    dcnt_r;
  logic [ETA_W-1:0]   eta_r;
  logic [STAT_W-1:0]  stat_r;

  logic              sig_pos, sig_gt;
  logic              use_left, single, sum_pos, num_pos, num_ge;
  logic [SIG_W-1:0]  s2, num;
  logic [CHAN_W-1:0] c2;
  logic [SIG_W:0]    sum, sh, sh_diff;
  logic              ge;

  assign sig_pos = !in_sig[SIG_W-1] && (in_sig != '0);
  assign sig_gt  = $signed(in_sig) > peak_sig_r;

  // second strip choice and sum
  always_comb begin
    if (at_first_r)    use_left = 1'b0;
    else if (!rpres_r) use_left = 1'b1;
    else               use_left = left_sig_r > right_sig_r;
    s2      = use_left ? left_sig_r : right_sig_r;
    c2      = use_left ? left_ch_r  : right_ch_r;
    sum     = {peak_sig_r[SIG_W-1], peak_sig_r} + {s2[SIG_W-1], s2};
    num     = (peak_ch_r > c2) ? peak_sig_r : s2;
    single  = cnt_r == CNT_W'(1);
    sum_pos = !sum[SIG_W] && (sum != '0);
    num_pos = !num[SIG_W-1] && (num != '0);
    num_ge  = num >= sum[SIG_W-1:0];
  end

  assign sts.need_div = !single && sum_pos && num_pos && !num_ge;
  assign sts.div_last = dcnt_r == DC_W'(ETA_FRAC_BITS - 1);

  // restoring divide step, remainder always below the divisor
  assign sh      = {rem_r, 1'b0};
  assign sh_diff = sh - {1'b0, den_r};
  assign ge      = sh >= {1'b0, den_r};

  always_ff @(posedge clk) begin
    if (!rst_n || cmd.eval) begin
      cnt_r       <= '0;
      peak_sig_r  <= '0;
      peak_ch_r   <= '0;
      at_first_r  <= 1'b1;
      left_sig_r  <= '0;
      left_ch_r   <= '0;
      right_sig_r <= '0;
      right_ch_r  <= '0;
      rpend_r     <= 1'b0;
      rpres_r     <= 1'b0;
      prev_sig_r  <= '0;
      prev_ch_r   <= '0;
    end else if (cmd.take) begin
      if (cnt_r == '0) begin
        peak_ch_r  <= in_chan;
        if (sig_pos) peak_sig_r <= in_sig;
        at_first_r <= 1'b1;
        rpend_r    <= 1'b1;
        rpres_r    <= 1'b0;
      end else if (sig_gt) begin
        peak_sig_r <= in_sig;
        peak_ch_r  <= in_chan;
        at_first_r <= 1'b0;
        left_sig_r <= prev_sig_r;
        left_ch_r  <= prev_ch_r;
        rpend_r    <= 1'b1;
        rpres_r    <= 1'b0;
      end else if (rpend_r) begin
        right_sig_r <= in_sig;
        right_ch_r  <= in_chan;
        rpres_r     <= 1'b1;
        rpend_r     <= 1'b0;
      end
      prev_sig_r <= in_sig;
      prev_ch_r  <= in_chan;
      if (cnt_r < CNT_W'(MAX_STRIPS)) cnt_r <= cnt_r + CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.eval) begin
      rem_r  <= num;
      den_r  <= sum[SIG_W-1:0];
      dcnt_r <= '0;
      if (single) begin
        res_r   <= '0;
        rstat_r <= STAT_SINGLE;
      end else if (!sum_pos) begin
        res_r   <= '0;
        rstat_r <= STAT_NONPOS;
      end else begin
        rstat_r <= STAT_OK;
        if (num_pos && num_ge) res_r <= {1'b1, {ETA_FRAC_BITS{1'b0}}};
        else                   res_r <= '0;
      end
    end else if (cmd.step) begin
      rem_r  <= ge ? sh_diff[SIG_W-1:0] : sh[SIG_W-1:0];
      res_r  <= {res_r[QW-2:0], ge};
      dcnt_r <= dcnt_r + DC_W'(1);
    end
    if (cmd.load_out) begin
      eta_r  <= ETA_W'(res_r);
      stat_r <= rstat_r;
    end
  end

  assign eta    = eta_r;
  assign status = stat_r;

endmodule

// ===== hw/rtl/strip_cluster_eta.sv =====
`timescale 1ns / 1ps
// channel | dir | tdata (low bit up)                    | tuser       | tlast
// in_     | in  | strip_signal[15:0], strip_channel[27:16] | -         | last_strip
// out_    | out | eta_fraction[16:0]                    | eta_status  | -
//
// strips are taken one per cycle while collecting; the strip marked last is
// followed by an evaluate state, the divide steps (only when a true fraction is
// needed) and the load of the output register, which waits while an earlier
// result is still stalled; the divide uses the bit-per-cycle restoring divider
// reset (rst_n low, synchronous) empties the output register and the cluster
// a stalled result waits in the output register; strips of the next cluster
// are taken meanwhile, only the next result waits for it to be transferred
module strip_cluster_eta #(
  parameter int MAX_STRIPS    = sce_pkg::MAX_STRIPS_DEF,
  parameter int ETA_FRAC_BITS = sce_pkg::ETA_FRAC_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  // strip_signal [15:0], strip_channel [27:16], zero fill above
  input  logic [sce_pkg::IN_TDATA_W-1:0]   in_tdata,
  input  logic                             in_tlast,   // last_strip
  input  logic                             in_tvalid,
  output logic                             in_tready,
  // eta_fraction [16:0], zero fill above
  output logic [sce_pkg::OUT_TDATA_W-1:0]  out_tdata,
  // eta_status [1:0]
  output logic [sce_pkg::STAT_W-1:0]       out_tuser,
  output logic                             out_tvalid,
  input  logic                             out_tready
);
  import sce_pkg::*;

  dp_cmd_t           cmd;
  dp_sts_t           sts;
  logic [ETA_W-1:0]  eta;

  // sequencing of collect, evaluate, divide and output load
  sce_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tlast   (in_tlast),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cmd        (cmd),
    .sts        (sts)
  );

  // peak and neighbor tracking, divider and output register
  sce_dp #(
    .MAX_STRIPS    (MAX_STRIPS),
    .ETA_FRAC_BITS (ETA_FRAC_BITS)
  ) u_dp (
    .clk     (clk),
    .rst_n   (rst_n),
    .cmd     (cmd),
    .sts     (sts),
    .in_sig  (in_tdata[SIG_W-1:0]),
    .in_chan (in_tdata[SIG_W+CHAN_W-1:SIG_W]),
    .eta     (eta),
    .status  (out_tuser)
  );

  assign out_tdata = OUT_TDATA_W'(eta);

  // a last strip transfer always stops intake while the result is built
  a_last_stops: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && in_tlast |=> !in_tready)
    else $error("intake not stopped after last strip");

  // any error status carries a zero fraction
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser != STAT_OK) |-> (out_tdata == '0))
    else $error("nonzero eta with error status");

  // a new result is loaded only from the wait state, never during intake
  a_load_no_intake: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> $past(!in_tready))
    else $error("result loaded while taking strips");

endmodule
